// ----- rtl/clsr_pkg.sv -----
// Shared types and constants for the change-logged sample ring.
package clsr_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int TEMP_W   = 8;
    localparam int LIGHT_W  = 2;
    // Record light field is one bit wider so it can hold the "none yet" mark.
    localparam int REC_LIGHT_W = 3;

    localparam logic [TEMP_W-1:0]      MIN_TEMP_INIT  = 8'd200;
    localparam logic [REC_LIGHT_W-1:0] MIN_LIGHT_NONE = 3'd5;

    // Bit positions in the extremes-changed flags.
    localparam int CHG_MAX_TEMP  = 0;
    localparam int CHG_MAX_LIGHT = 1;
    localparam int CHG_MIN_TEMP  = 2;
    localparam int CHG_MIN_LIGHT = 3;
    localparam int CHG_W         = 4;

    // One timestamped sample as it enters and as it is logged.
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [TEMP_W-1:0]   temperature;
        logic [LIGHT_W-1:0]  light;
    } sample_t;

    // One extreme record: timestamp and both values.
    typedef struct packed {
        logic [HOUR_W-1:0]      hour;
        logic [MINUTE_W-1:0]    minute;
        logic [SECOND_W-1:0]    second;
        logic [TEMP_W-1:0]      temperature;
        logic [REC_LIGHT_W-1:0] light;
    } record_t;

    // Flags from the log controller for one request.
    typedef struct packed {
        logic logged;
        logic notice;
    } log_flags_t;

    // Extreme values and refresh flags for one request.
    typedef struct packed {
        logic [CHG_W-1:0]       changed;
        logic [TEMP_W-1:0]      max_temp;
        logic [TEMP_W-1:0]      min_temp;
        logic [LIGHT_W-1:0]     max_light;
        logic [REC_LIGHT_W-1:0] min_light;
    } ext_result_t;

endpackage

// ----- rtl/change_logged_sample_ring_with_extremes.sv -----
// Top level: sample ring log with extreme records and a registered result stage.
// The result of an accepted request sits in the output register from the next cycle on.
// Throughput: one request per cycle while the output register is empty or being drained.
// The state update is a single compare-and-select pass.
// Reset clears write slot, entry count, newest entry, max records; presets min records.
// The log memory is not cleared; it is write-only and never read back.
module change_logged_sample_ring_with_extremes
    import clsr_pkg::*;
#(
    parameter int LOG_DEPTH    = 20,
    parameter int NOTICE_COUNT = 10,
    localparam int SLOT_W      = $clog2(LOG_DEPTH),
    localparam int CNT_W       = $clog2(LOG_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [HOUR_W-1:0]      hour,
    input  logic [MINUTE_W-1:0]    minute,
    input  logic [SECOND_W-1:0]    second,
    input  logic [TEMP_W-1:0]      temperature,
    input  logic [LIGHT_W-1:0]     light_level,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   logged,
    output logic [SLOT_W-1:0]      slot,
    output logic [CNT_W-1:0]       entry_count,
    output logic                   half_full_notice,
    output logic [CHG_W-1:0]       extremes_changed,
    output logic [TEMP_W-1:0]      max_temperature,
    output logic [TEMP_W-1:0]      min_temperature,
    output logic [LIGHT_W-1:0]     max_light,
    output logic [REC_LIGHT_W-1:0] min_light
);

    sample_t           sample;
    logic              accept;
    log_flags_t        flags;
    logic [SLOT_W-1:0] slot_now;
    logic [CNT_W-1:0]  count_now;
    ext_result_t       ext;

    logic              out_valid_reg, out_valid_next;
    log_flags_t        flags_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  count_reg;
    ext_result_t       ext_reg;

    // Handshake: take a request whenever the result register can move.
    always_comb
    begin
        in_ready = !out_valid_reg || out_ready;
        accept   = in_valid && in_ready;
        sample   = '{hour: hour, minute: minute, second: second,
                     temperature: temperature, light: light_level};
    end

    clsr_log_ctrl #(
        .LOG_DEPTH    (LOG_DEPTH),
        .NOTICE_COUNT (NOTICE_COUNT),
        .SLOT_W       (SLOT_W),
        .CNT_W        (CNT_W)
    ) u_log (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (sample),
        .flags       (flags),
        .slot        (slot_now),
        .entry_count (count_now)
    );

    clsr_extremes u_ext (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .result (ext)
    );

    // Output valid follows accepts and drains.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags;
            slot_reg  <= slot_now;
            count_reg <= count_now;
            ext_reg   <= ext;
        end
    end

    always_comb
    begin
        out_valid        = out_valid_reg;
        logged           = flags_reg.logged;
        half_full_notice = flags_reg.notice;
        slot             = slot_reg;
        entry_count      = count_reg;
        extremes_changed = ext_reg.changed;
        max_temperature  = ext_reg.max_temp;
        min_temperature  = ext_reg.min_temp;
        max_light        = ext_reg.max_light;
        min_light        = ext_reg.min_light;
    end

    // An accepted request always shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
        else $error("accepted request produced no result");

    // A logged sample leaves at least one entry in the log.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && logged) |-> (entry_count != '0))
        else $error("logged sample with empty log");

    // The notice only comes with an append.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && half_full_notice) |-> logged)
        else $error("notice without append");

    // The entry count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CNT_W'(LOG_DEPTH)))
        else $error("entry count beyond depth");

endmodule

// ----- rtl/clsr_log_ctrl.sv -----
// Circular log: write slot, entry count, newest-entry compare and log memory.
module clsr_log_ctrl
    import clsr_pkg::*;
#(
    parameter int LOG_DEPTH    = 20,
    parameter int NOTICE_COUNT = 10,
    parameter int SLOT_W       = $clog2(LOG_DEPTH),
    parameter int CNT_W        = $clog2(LOG_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  sample_t           sample,
    output log_flags_t        flags,
    output logic [SLOT_W-1:0] slot,
    output logic [CNT_W-1:0]  entry_count
);

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(LOG_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(LOG_DEPTH);
    localparam bit                NOTICE_ON  = (NOTICE_COUNT <= LOG_DEPTH);
    localparam logic [CNT_W-1:0]  NOTICE_VAL = CNT_W'(NOTICE_COUNT);

    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TEMP_W-1:0]  newest_temp_reg, newest_temp_next;
    logic [LIGHT_W-1:0] newest_light_reg, newest_light_next;
    logic               log_now;
    logic               count_grows;
    sample_t            log_mem [LOG_DEPTH];

    // Append when the log is empty or the values differ from the newest entry.
    always_comb
    begin
        log_now = (count_reg == '0) ||
                  (sample.temperature != newest_temp_reg) ||
                  (sample.light != newest_light_reg);
        count_grows = log_now && (count_reg != FULL_COUNT);
    end

    // Next-state logic for slot, count and the newest entry.
    always_comb
    begin
        write_slot_next   = write_slot_reg;
        count_next        = count_reg;
        newest_temp_next  = newest_temp_reg;
        newest_light_next = newest_light_reg;
        if (accept && log_now)
        begin
            write_slot_next   = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;
            newest_temp_next  = sample.temperature;
            newest_light_next = sample.light;
            if (count_grows)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Result fields for the current request.
    always_comb
    begin
        flags.logged = log_now;
        flags.notice = NOTICE_ON && count_grows && ((count_reg + 1'b1) == NOTICE_VAL);
        slot         = write_slot_reg;
        entry_count  = count_grows ? count_reg + 1'b1 : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg   <= '0;
            count_reg        <= '0;
            newest_temp_reg  <= '0;
            newest_light_reg <= '0;
        end
        else
        begin
            write_slot_reg   <= write_slot_next;
            count_reg        <= count_next;
            newest_temp_reg  <= newest_temp_next;
            newest_light_reg <= newest_light_next;
        end
    end

    // Log storage, written at the current slot on each append.
    always_ff @(posedge clk)
    begin
        if (accept && log_now)
        begin
            log_mem[write_slot_reg] <= sample;
        end
    end

endmodule

// ----- rtl/clsr_extremes.sv -----
// Max and min records for temperature and light, refreshed on ties.
module clsr_extremes
    import clsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  sample_t     sample,
    output ext_result_t result
);

    record_t max_temp_reg, max_temp_next;
    record_t max_light_reg, max_light_next;
    record_t min_temp_reg, min_temp_next;
    record_t min_light_reg, min_light_next;
    record_t sample_rec;
    logic [REC_LIGHT_W-1:0] light_ext;
    logic [CHG_W-1:0] changed;

    // Compare the sample against each record.
    always_comb
    begin
        light_ext  = {1'b0, sample.light};
        sample_rec = '{hour: sample.hour, minute: sample.minute, second: sample.second,
                       temperature: sample.temperature, light: light_ext};
        changed                = '0;
        changed[CHG_MAX_TEMP]  = sample.temperature >= max_temp_reg.temperature;
        changed[CHG_MAX_LIGHT] = light_ext >= max_light_reg.light;
        changed[CHG_MIN_TEMP]  = sample.temperature <= min_temp_reg.temperature;
        changed[CHG_MIN_LIGHT] = light_ext <= min_light_reg.light;
    end

    // Record updates on an accepted request.
    always_comb
    begin
        max_temp_next  = max_temp_reg;
        max_light_next = max_light_reg;
        min_temp_next  = min_temp_reg;
        min_light_next = min_light_reg;
        if (accept)
        begin
            if (changed[CHG_MAX_TEMP])
            begin
                max_temp_next = sample_rec;
            end
            if (changed[CHG_MAX_LIGHT])
            begin
                max_light_next = sample_rec;
            end
            if (changed[CHG_MIN_TEMP])
            begin
                min_temp_next = sample_rec;
            end
            if (changed[CHG_MIN_LIGHT])
            begin
                min_light_next = sample_rec;
            end
        end
    end

    // Values after this sample are the updated records.
    always_comb
    begin
        result.changed   = changed;
        result.max_temp  = max_temp_next.temperature;
        result.min_temp  = min_temp_next.temperature;
        result.max_light = max_light_next.light[LIGHT_W-1:0];
        result.min_light = min_light_next.light;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temp_reg  <= '0;
            max_light_reg <= '0;
            min_temp_reg  <= '{hour: '0, minute: '0, second: '0,
                               temperature: MIN_TEMP_INIT, light: '0};
            min_light_reg <= '{hour: '0, minute: '0, second: '0,
                               temperature: '0, light: MIN_LIGHT_NONE};
        end
        else
        begin
            max_temp_reg  <= max_temp_next;
            max_light_reg <= max_light_next;
            min_temp_reg  <= min_temp_next;
            min_light_reg <= min_light_next;
        end
    end

endmodule
